// ===== sv/tdor_pkg.sv =====
// Shared constants and types for the torus dimension-order router.
package tdor_pkg;

   localparam int MAX_DIMS     = 3;
   localparam int MAX_DIM_SIZE = 16;
   localparam int ID_W         = 12;
   localparam int CRD_W        = (MAX_DIM_SIZE > 2) ? $clog2(MAX_DIM_SIZE) : 1;
   localparam int SZ_W         = CRD_W + 1;
   localparam int DIM_W        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DCNT_W       = $clog2(MAX_DIMS + 1);
   localparam int STEP_W       = $clog2(ID_W);
   localparam int OUT_MAX      = 64;
   localparam int NCNT_W       = $clog2(OUT_MAX);
   localparam int QUEUE_DEPTH  = 2;
   localparam int DIM_CNT_W    = 2;
   localparam int SIZE_CFG_W   = 5;

   typedef enum logic [1:0] {
      KIND_HOP      = 2'd0,
      KIND_SEND_LIM = 2'd1,
      KIND_RECV_LIM = 2'd2,
      KIND_LOOPBACK = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CSR_DIM_COUNT   = 3'd0,
      CSR_SIZE_X      = 3'd1,
      CSR_SIZE_Y      = 3'd2,
      CSR_SIZE_Z      = 3'd3,
      CSR_LOOPBACK_ON = 3'd4,
      CSR_LIMITER_ON  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DIM_CNT_W-1:0]  dim_count;
      logic [SIZE_CFG_W-1:0] size_x;
      logic [SIZE_CFG_W-1:0] size_y;
      logic [SIZE_CFG_W-1:0] size_z;
      logic                  loopback_on;
      logic                  limiter_on;
   } cfg_type;

   // One classified route, handed from the front end to the walker.
   typedef struct packed {
      logic                              loop;
      logic                              lim;
      logic [ID_W-1:0]                   src;
      logic [ID_W-1:0]                   dst;
      logic [MAX_DIMS-1:0]               move;
      logic [MAX_DIMS-1:0]               go_up;
      logic [MAX_DIMS-1:0][CRD_W-1:0]    m;
      logic [MAX_DIMS-1:0][CRD_W-1:0]    t;
      logic [MAX_DIMS-1:0][SZ_W-1:0]     size;
      logic [MAX_DIMS-1:0][ID_W-1:0]     stride;
      logic [MAX_DIMS-1:0][ID_W-1:0]     wrap;
   } item_type;

endpackage

// ===== sv/tdor_front.sv =====
// Front end: accepts requests, splits ids into coordinates and classifies the route.
module tdor_front import tdor_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [ID_W-1:0] req_src_node,
   input  logic [ID_W-1:0] req_dst_node,
   input  logic            req_end_is_router,
   output logic            push_valid,
   output item_type        push_item,
   input  logic            queue_full
);

   typedef enum logic [3:0] {
      F_IDLE   = 4'b0001,
      F_STRIDE = 4'b0010,
      F_DIV    = 4'b0100,
      F_PUSH   = 4'b1000
   } fstate_type;

   fstate_type            state_ff, state_in;
   logic [ID_W-1:0]       src_ff, src_in, dst_ff, dst_in;
   logic [DCNT_W-1:0]     nd_ff, nd_in;
   logic                  loop_ff, loop_in, lim_ff, lim_in, oor_ff, oor_in;
   logic [SZ_W-1:0]       size_ff [MAX_DIMS];
   logic [SZ_W-1:0]       size_in [MAX_DIMS];
   logic [ID_W-1:0]       stride_ff [MAX_DIMS+1];
   logic [ID_W-1:0]       stride_in [MAX_DIMS+1];
   logic [CRD_W-1:0]      m_ff [MAX_DIMS];
   logic [CRD_W-1:0]      m_in [MAX_DIMS];
   logic [CRD_W-1:0]      t_ff [MAX_DIMS];
   logic [CRD_W-1:0]      t_in [MAX_DIMS];
   logic [ID_W-1:0]       qs_ff, qs_in, qd_ff, qd_in;
   logic [CRD_W-1:0]      rs_ff, rs_in, rd_ff, rd_in;
   logic [DCNT_W-1:0]     k_ff, k_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic [DIM_W-1:0]      kx;
   logic [SZ_W-1:0]       cur_size;
   logic [ID_W+SZ_W-1:0]  prod;
   logic [SZ_W-1:0]       rem_s, rem_d;
   logic                  ge_s, ge_d;
   logic [CRD_W-1:0]      rs_nx, rd_nx;
   logic [ID_W-1:0]       qs_nx, qd_nx;
   logic                  drop;
   logic [SZ_W-1:0]       half_w [MAX_DIMS];
   logic [SZ_W-1:0]       mh_w [MAX_DIMS];
   logic [SZ_W-1:0]       mhm_w [MAX_DIMS];

   function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] s);
      logic [SZ_W-1:0] r;
      if (s == '0) begin
         r = SZ_W'(1);
      end else if (int'(s) > MAX_DIM_SIZE) begin
         r = SZ_W'(MAX_DIM_SIZE);
      end else begin
         r = SZ_W'(s);
      end
      return r;
   endfunction

   function automatic logic [SZ_W-1:0] cfg_size(input cfg_type c, input int k);
      logic [SZ_W-1:0] r;
      case (k)
         0:       r = clamp_size(c.size_x);
         1:       r = clamp_size(c.size_y);
         2:       r = clamp_size(c.size_z);
         default: r = SZ_W'(1);
      endcase
      return r;
   endfunction

   assign req_stall = (state_ff != F_IDLE);

   assign kx       = k_ff[DIM_W-1:0];
   assign cur_size = size_ff[kx];
   assign prod     = (ID_W+SZ_W)'(stride_ff[kx]) * (ID_W+SZ_W)'(cur_size);

   // One restoring-division step for each id: the remainder after a whole
   // dimension is its coordinate, the quotient feeds the next dimension.
   assign rem_s = {rs_ff, qs_ff[ID_W-1]};
   assign rem_d = {rd_ff, qd_ff[ID_W-1]};
   assign ge_s  = (rem_s >= cur_size);
   assign ge_d  = (rem_d >= cur_size);
   assign rs_nx = ge_s ? CRD_W'(rem_s - cur_size) : rem_s[CRD_W-1:0];
   assign rd_nx = ge_d ? CRD_W'(rem_d - cur_size) : rem_d[CRD_W-1:0];
   assign qs_nx = {qs_ff[ID_W-2:0], ge_s};
   assign qd_nx = {qd_ff[ID_W-2:0], ge_d};

   assign drop = oor_ff || ((src_ff == dst_ff) && !loop_ff && !lim_ff);

   always_comb begin
      push_item.loop = loop_ff && (src_ff == dst_ff);
      push_item.lim  = lim_ff;
      push_item.src  = src_ff;
      push_item.dst  = dst_ff;
      for (int k = 0; k < MAX_DIMS; k++) begin
         half_w[k] = size_ff[k] >> 1;
         mh_w[k]   = SZ_W'(m_ff[k]) + half_w[k];
         mhm_w[k]  = (mh_w[k] >= size_ff[k]) ? SZ_W'(mh_w[k] - size_ff[k]) : mh_w[k];
         push_item.go_up[k] = ((t_ff[k] > m_ff[k]) && (SZ_W'(t_ff[k]) <= mh_w[k])) ||
                              ((SZ_W'(m_ff[k]) > half_w[k]) && (mhm_w[k] >= SZ_W'(t_ff[k])));
         push_item.move[k]   = (DCNT_W'(k) < nd_ff) && (m_ff[k] != t_ff[k]);
         push_item.m[k]      = m_ff[k];
         push_item.t[k]      = t_ff[k];
         push_item.size[k]   = size_ff[k];
         push_item.stride[k] = stride_ff[k];
         // Arithmetic is modulo the id width, which keeps the wrap jump exact.
         push_item.wrap[k]   = stride_ff[k+1] - stride_ff[k];
      end
   end

   assign push_valid = (state_ff == F_PUSH) && !drop && !queue_full;

   always_comb begin
      state_in  = state_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      nd_in     = nd_ff;
      loop_in   = loop_ff;
      lim_in    = lim_ff;
      oor_in    = oor_ff;
      size_in   = size_ff;
      stride_in = stride_ff;
      m_in      = m_ff;
      t_in      = t_ff;
      qs_in     = qs_ff;
      qd_in     = qd_ff;
      rs_in     = rs_ff;
      rd_in     = rd_ff;
      k_in      = k_ff;
      step_in   = step_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !req_end_is_router) begin
               src_in  = req_src_node;
               dst_in  = req_dst_node;
               loop_in = cfg.loopback_on;
               lim_in  = cfg.limiter_on;
               if (cfg.dim_count == '0) begin
                  nd_in = DCNT_W'(1);
               end else if (int'(cfg.dim_count) > MAX_DIMS) begin
                  nd_in = DCNT_W'(MAX_DIMS);
               end else begin
                  nd_in = DCNT_W'(cfg.dim_count);
               end
               for (int k = 0; k < MAX_DIMS; k++) begin
                  size_in[k] = cfg_size(cfg, k);
               end
               stride_in[0] = ID_W'(1);
               k_in         = '0;
               state_in     = F_STRIDE;
            end
         end
         F_STRIDE: begin
            stride_in[DCNT_W'(k_ff + 1'b1)] = prod[ID_W-1:0];
            if (k_ff == DCNT_W'(MAX_DIMS - 1)) begin
               k_in     = '0;
               step_in  = '0;
               qs_in    = src_ff;
               qd_in    = dst_ff;
               rs_in    = '0;
               rd_in    = '0;
               oor_in   = 1'b0;
               state_in = F_DIV;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         F_DIV: begin
            qs_in   = qs_nx;
            qd_in   = qd_nx;
            rs_in   = rs_nx;
            rd_in   = rd_nx;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ID_W - 1)) begin
               m_in[kx] = rs_nx;
               t_in[kx] = rd_nx;
               rs_in    = '0;
               rd_in    = '0;
               step_in  = '0;
               // An id lies in the torus when nothing is left above the last dimension.
               if (k_ff == DCNT_W'(nd_ff - 1'b1)) begin
                  oor_in = (qs_nx != '0) || (qd_nx != '0);
               end
               if (k_ff == DCNT_W'(MAX_DIMS - 1)) begin
                  state_in = F_PUSH;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         F_PUSH: begin
            if (drop || !queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      nd_ff     <= nd_in;
      loop_ff   <= loop_in;
      lim_ff    <= lim_in;
      oor_ff    <= oor_in;
      size_ff   <= size_in;
      stride_ff <= stride_in;
      m_ff      <= m_in;
      t_ff      <= t_in;
      qs_ff     <= qs_in;
      qd_ff     <= qd_in;
      rs_ff     <= rs_in;
      rd_ff     <= rd_in;
      k_ff      <= k_in;
      step_ff   <= step_in;
   end

endmodule

// ===== sv/tdor_queue.sv =====
// Short queue of classified routes between the front end and the walker.
module tdor_queue import tdor_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == QC_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/tdor_back.sv =====
// Route walker: walks the dimensions, one link entry per cycle unless stalled.
module tdor_back import tdor_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  item_type        head_item,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_entry_kind,
   output logic [ID_W-1:0] rsp_link_node,
   output logic [1:0]      rsp_link_dim,
   output logic            rsp_use_up,
   output logic            rsp_last
);

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_SEEK = 6'b000010,
      B_SLIM = 6'b000100,
      B_HOP  = 6'b001000,
      B_RLIM = 6'b010000,
      B_LOOP = 6'b100000
   } bstate_type;

   bstate_type         state_ff, state_in;
   item_type           it_ff, it_in;
   logic [DCNT_W-1:0]  j_ff, j_in;
   logic [CRD_W-1:0]   c_ff, c_in;
   logic [ID_W-1:0]    cur_ff, cur_in;
   logic [NCNT_W-1:0]  n_ff, n_in;
   logic               valid_ff, valid_in;
   kind_type           kind_ff, kind_in;
   logic [ID_W-1:0]    node_ff, node_in;
   logic [1:0]         dim_ff, dim_in;
   logic               up_ff, up_in, last_ff, last_in;

   logic [DIM_W-1:0]   jx;
   logic [SZ_W-1:0]    s;
   logic               go_up, at_top, at_bot, later, cap, hop_end, emit_ok, emit;
   logic [ID_W-1:0]    nbr_node;
   logic [CRD_W-1:0]   next_c;

   assign jx      = j_ff[DIM_W-1:0];
   assign s       = it_ff.size[jx];
   assign go_up   = it_ff.go_up[jx];
   assign at_top  = (SZ_W'(c_ff) == SZ_W'(s - 1'b1));
   assign at_bot  = (c_ff == '0);
   assign cap     = (n_ff == NCNT_W'(OUT_MAX - 1));
   assign emit_ok = !valid_ff || !rsp_stall;

   always_comb begin
      if (go_up) begin
         nbr_node = at_top ? cur_ff - it_ff.wrap[jx] : cur_ff + it_ff.stride[jx];
         next_c   = at_top ? '0 : c_ff + 1'b1;
      end else begin
         nbr_node = at_bot ? cur_ff + it_ff.wrap[jx] : cur_ff - it_ff.stride[jx];
         next_c   = at_bot ? CRD_W'(s - 1'b1) : c_ff - 1'b1;
      end
   end

   // Any move still pending in a later dimension.
   always_comb begin
      later = 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         if (DCNT_W'(k) > j_ff) begin
            later = later | it_ff.move[k];
         end
      end
   end

   assign hop_end = (next_c == it_ff.t[jx]) && !later && !it_ff.lim;

   always_comb begin
      state_in = state_ff;
      it_in    = it_ff;
      j_in     = j_ff;
      c_in     = c_ff;
      cur_in   = cur_ff;
      n_in     = n_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      kind_in  = kind_ff;
      node_in  = node_ff;
      dim_in   = dim_ff;
      up_in    = up_ff;
      last_in  = last_ff;
      case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               it_in    = head_item;
               cur_in   = head_item.src;
               j_in     = '0;
               n_in     = '0;
               state_in = head_item.loop ? B_LOOP : B_SEEK;
            end
         end
         B_SEEK: begin
            if (j_ff == DCNT_W'(MAX_DIMS)) begin
               state_in = it_ff.lim ? B_RLIM : B_IDLE;
            end else if (it_ff.move[jx]) begin
               c_in     = it_ff.m[jx];
               state_in = it_ff.lim ? B_SLIM : B_HOP;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         B_SLIM: begin
            if (emit_ok) begin
               emit     = 1'b1;
               kind_in  = KIND_SEND_LIM;
               node_in  = cur_ff;
               dim_in   = '0;
               up_in    = 1'b1;
               last_in  = cap;
               n_in     = n_ff + 1'b1;
               state_in = cap ? B_IDLE : B_HOP;
            end
         end
         B_HOP: begin
            if (emit_ok) begin
               emit    = 1'b1;
               kind_in = KIND_HOP;
               node_in = go_up ? cur_ff : nbr_node;
               dim_in  = 2'(j_ff);
               up_in   = go_up;
               last_in = cap || hop_end;
               n_in    = n_ff + 1'b1;
               cur_in  = nbr_node;
               c_in    = next_c;
               if (cap || hop_end) begin
                  state_in = B_IDLE;
               end else if (next_c == it_ff.t[jx]) begin
                  j_in     = j_ff + 1'b1;
                  state_in = B_SEEK;
               end else begin
                  state_in = it_ff.lim ? B_SLIM : B_HOP;
               end
            end
         end
         B_RLIM: begin
            if (emit_ok) begin
               emit     = 1'b1;
               kind_in  = KIND_RECV_LIM;
               node_in  = it_ff.dst;
               dim_in   = '0;
               up_in    = 1'b0;
               last_in  = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_LOOP: begin
            if (emit_ok) begin
               emit     = 1'b1;
               kind_in  = KIND_LOOPBACK;
               node_in  = it_ff.src;
               dim_in   = '0;
               up_in    = 1'b1;
               last_in  = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      valid_in = emit || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff   <= it_in;
      j_ff    <= j_in;
      c_ff    <= c_in;
      cur_ff  <= cur_in;
      n_ff    <= n_in;
      kind_ff <= kind_in;
      node_ff <= node_in;
      dim_ff  <= dim_in;
      up_ff   <= up_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_entry_kind = kind_ff;
   assign rsp_link_node  = node_ff;
   assign rsp_link_dim   = dim_ff;
   assign rsp_use_up     = up_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== sv/torus_dimension_order_router_unit.sv =====
// The front end's bit-serial coordinate divider decodes one request at a time and holds
// req_stall until the decoded route has entered the queue or been dropped. The walker emits
// one route entry per cycle while walking a dimension and the receiver does not stall; a
// two-deep queue lets the front end decode the next request meanwhile.
// Reset is synchronous: registers return to three 4x4x4 dimensions, the queue empties.
module torus_dimension_order_router_unit import tdor_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [ID_W-1:0] req_src_node,
   input  logic [ID_W-1:0] req_dst_node,
   input  logic            req_end_is_router,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_entry_kind,
   output logic [ID_W-1:0] rsp_link_node,
   output logic [1:0]      rsp_link_dim,
   output logic            rsp_use_up,
   output logic            rsp_last,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_index;
   logic          csr_write;
   logic          push_valid, queue_full, pop, head_valid;
   item_type      push_item, head_item;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DIM_COUNT:   cfg_in.dim_count   = csr_pwdata[DIM_CNT_W-1:0];
            CSR_SIZE_X:      cfg_in.size_x      = csr_pwdata[SIZE_CFG_W-1:0];
            CSR_SIZE_Y:      cfg_in.size_y      = csr_pwdata[SIZE_CFG_W-1:0];
            CSR_SIZE_Z:      cfg_in.size_z      = csr_pwdata[SIZE_CFG_W-1:0];
            CSR_LOOPBACK_ON: cfg_in.loopback_on = csr_pwdata[0];
            CSR_LIMITER_ON:  cfg_in.limiter_on  = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DIM_COUNT:   csr_prdata = 32'(cfg_ff.dim_count);
         CSR_SIZE_X:      csr_prdata = 32'(cfg_ff.size_x);
         CSR_SIZE_Y:      csr_prdata = 32'(cfg_ff.size_y);
         CSR_SIZE_Z:      csr_prdata = 32'(cfg_ff.size_z);
         CSR_LOOPBACK_ON: csr_prdata = 32'(cfg_ff.loopback_on);
         CSR_LIMITER_ON:  csr_prdata = 32'(cfg_ff.limiter_on);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_count   <= DIM_CNT_W'(3);
         cfg_ff.size_x      <= SIZE_CFG_W'(4);
         cfg_ff.size_y      <= SIZE_CFG_W'(4);
         cfg_ff.size_z      <= SIZE_CFG_W'(4);
         cfg_ff.loopback_on <= 1'b0;
         cfg_ff.limiter_on  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tdor_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_src_node      (req_src_node),
      .req_dst_node      (req_dst_node),
      .req_end_is_router (req_end_is_router),
      .push_valid        (push_valid),
      .push_item         (push_item),
      .queue_full        (queue_full)
   );

   tdor_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   tdor_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_entry_kind (rsp_entry_kind),
      .rsp_link_node  (rsp_link_node),
      .rsp_link_dim   (rsp_link_dim),
      .rsp_use_up     (rsp_use_up),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sim/tb_torus_dimension_order_router_unit.sv =====
// Self-checking testbench for the torus dimension-order router unit.
module tb_torus_dimension_order_router_unit import tdor_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] node;
      logic [1:0]      dim;
      logic            up;
      logic            last;
   } route_entry_type;

   typedef struct {
      int              cfg_idx;
      logic [ID_W-1:0] src;
      logic [ID_W-1:0] dst;
      logic            rtr;
      bit              typed;
      int              count;
      kind_type        kind;
      logic [ID_W-1:0] node;
      logic            up;
   } route_case_type;

   localparam int ROUTE_CAP    = 64;
   localparam int BUSY_CYCLES  = 3 + 13 * MAX_DIMS + 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SEG_ITEMS    = 34;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   logic [ID_W-1:0] req_src_node;
   logic [ID_W-1:0] req_dst_node;
   logic            req_end_is_router;
   logic            rsp_valid;
   logic            rsp_stall;
   logic [1:0]      rsp_entry_kind;
   logic [ID_W-1:0] rsp_link_node;
   logic [1:0]      rsp_link_dim;
   logic            rsp_use_up;
   logic            rsp_last;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [4:0]      csr_paddr;
   logic [31:0]     csr_pwdata;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   route_entry_type expected_entries[$];
   cfg_type         route_cfg;
   int              fail_count = 0;
   int              quiet_cycles = 0;
   int              snd_idle_pct;
   int              rcv_stall_pct;

   cfg_type torus_sets [7] = '{
      '{2'd3, 5'd4,  5'd4,  5'd4,  1'b0, 1'b0},
      '{2'd3, 5'd4,  5'd4,  5'd4,  1'b1, 1'b1},
      '{2'd1, 5'd16, 5'd0,  5'd31, 1'b0, 1'b1},
      '{2'd3, 5'd16, 5'd16, 5'd16, 1'b0, 1'b1},
      '{2'd0, 5'd31, 5'd3,  5'd2,  1'b1, 1'b0},
      '{2'd2, 5'd1,  5'd5,  5'd4,  1'b0, 1'b0},
      '{2'd3, 5'd0,  5'd0,  5'd0,  1'b1, 1'b1}
   };

   // Rows marked typed carry their whole answer: no result, or one single entry.
   route_case_type directed_rows [25] = '{
      '{0, 0,    0,    0, 1, 0, KIND_HOP,      0, 0},
      '{0, 0,    63,   0, 0, 0, KIND_HOP,      0, 0},
      '{0, 5,    6,    1, 1, 0, KIND_HOP,      0, 0},
      '{0, 64,   0,    0, 1, 0, KIND_HOP,      0, 0},
      '{0, 0,    4095, 0, 1, 0, KIND_HOP,      0, 0},
      '{1, 7,    7,    0, 1, 1, KIND_LOOPBACK, 7, 1},
      '{1, 0,    1,    0, 0, 0, KIND_HOP,      0, 0},
      '{1, 3,    0,    0, 0, 0, KIND_HOP,      0, 0},
      '{1, 63,   0,    0, 0, 0, KIND_HOP,      0, 0},
      '{1, 4095, 4095, 1, 1, 0, KIND_HOP,      0, 0},
      '{2, 0,    15,   0, 0, 0, KIND_HOP,      0, 0},
      '{2, 15,   0,    0, 0, 0, KIND_HOP,      0, 0},
      '{2, 9,    1,    0, 0, 0, KIND_HOP,      0, 0},
      '{2, 0,    8,    0, 0, 0, KIND_HOP,      0, 0},
      '{2, 16,   0,    0, 1, 0, KIND_HOP,      0, 0},
      '{2, 5,    5,    0, 1, 1, KIND_RECV_LIM, 5, 0},
      '{3, 0,    4095, 0, 0, 0, KIND_HOP,      0, 0},
      '{3, 4095, 0,    0, 0, 0, KIND_HOP,      0, 0},
      '{3, 2730, 1365, 0, 0, 0, KIND_HOP,      0, 0},
      '{4, 3,    12,   0, 0, 0, KIND_HOP,      0, 0},
      '{4, 16,   3,    0, 1, 0, KIND_HOP,      0, 0},
      '{4, 9,    9,    0, 1, 1, KIND_LOOPBACK, 9, 1},
      '{5, 0,    4,    0, 0, 0, KIND_HOP,      0, 0},
      '{6, 0,    0,    0, 1, 1, KIND_LOOPBACK, 0, 1},
      '{6, 0,    1,    0, 1, 0, KIND_HOP,      0, 0}
   };

   torus_dimension_order_router_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_src_node      (req_src_node),
      .req_dst_node      (req_dst_node),
      .req_end_is_router (req_end_is_router),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_entry_kind    (rsp_entry_kind),
      .rsp_link_node     (rsp_link_node),
      .rsp_link_dim      (rsp_link_dim),
      .rsp_use_up        (rsp_use_up),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int unsigned ring_len(input logic [4:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_SIZE) return MAX_DIM_SIZE;
      return v;
   endfunction

   function automatic int unsigned dims_in_use();
      if (route_cfg.dim_count == 0) return 1;
      if (route_cfg.dim_count > MAX_DIMS) return MAX_DIMS;
      return route_cfg.dim_count;
   endfunction

   function automatic int unsigned node_count();
      int unsigned total;
      total = ring_len(route_cfg.size_x);
      if (dims_in_use() > 1) total = total * ring_len(route_cfg.size_y);
      if (dims_in_use() > 2) total = total * ring_len(route_cfg.size_z);
      return total;
   endfunction

   function automatic void add_entry(inout int n, input kind_type k,
                                     input int unsigned node, input int unsigned dim,
                                     input logic up);
      route_entry_type e;
      if (n >= ROUTE_CAP) return;
      e.kind = k;
      e.node = ID_W'(node);
      e.dim  = 2'(dim);
      e.up   = up;
      e.last = 1'b0;
      expected_entries.insert(expected_entries.size(), e);
      n++;
   endfunction

   // Appends the link selections of one route to the expected entries.
   function automatic void plan_route(input logic [ID_W-1:0] src,
                                      input logic [ID_W-1:0] dst, input logic rtr);
      int unsigned len [3];
      int unsigned nd, stride, cur, m, t, c, nxt, half, s, j;
      int n;
      bit up;
      n = 0;
      if (rtr || src >= node_count() || dst >= node_count()) return;
      len[0] = ring_len(route_cfg.size_x);
      len[1] = ring_len(route_cfg.size_y);
      len[2] = ring_len(route_cfg.size_z);
      nd = dims_in_use();
      if (src == dst && route_cfg.loopback_on) begin
         add_entry(n, KIND_LOOPBACK, src, 0, 1'b1);
      end else begin
         cur = src;
         stride = 1;
         for (j = 0; j < nd; j++) begin
            s = len[j];
            half = s / 2;
            m = (src / stride) % s;
            t = (dst / stride) % s;
            // The direction is fixed once per dimension from the source coordinate.
            up = (t > m && t <= m + half) || (m > half && (m + half) % s >= t);
            while ((cur / stride) % s != t && n < ROUTE_CAP) begin
               c = (cur / stride) % s;
               if (route_cfg.limiter_on) add_entry(n, KIND_SEND_LIM, cur, 0, 1'b1);
               if (up) begin
                  nxt = (c == s - 1) ? cur - (s - 1) * stride : cur + stride;
                  add_entry(n, KIND_HOP, cur, j, 1'b1);
               end else begin
                  nxt = (c == 0) ? cur + (s - 1) * stride : cur - stride;
                  add_entry(n, KIND_HOP, nxt, j, 1'b0);
               end
               cur = nxt;
            end
            stride = stride * s;
         end
         if (route_cfg.limiter_on) add_entry(n, KIND_RECV_LIM, dst, 0, 1'b0);
      end
      if (n > 0) begin
         expected_entries[expected_entries.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic logic [4:0] random_len();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 5'd0;
      if (r == 1) return 5'($urandom_range(17, 31));
      if (r == 2) return 5'd16;
      return 5'($urandom_range(1, 6));
   endfunction

   function automatic cfg_type random_torus();
      cfg_type c;
      c.dim_count   = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      c.size_x      = random_len();
      c.size_y      = random_len();
      c.size_z      = random_len();
      c.loopback_on = 1'($urandom_range(1));
      c.limiter_on  = 1'($urandom_range(1));
      return c;
   endfunction

   // Starts at any point after a rising edge and returns at the edge that takes the item.
   task automatic send_route(input logic [ID_W-1:0] s, input logic [ID_W-1:0] d,
                             input logic r);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_src_node      = s;
      req_dst_node      = d;
      req_end_is_router = r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_route();
      logic [ID_W-1:0] s, d;
      logic r;
      int unsigned total;
      int sel;
      total = node_count();
      sel = $urandom_range(99);
      r = 1'b0;
      s = ID_W'($urandom_range(total - 1));
      d = ID_W'($urandom_range(total - 1));
      if (sel < 6) begin
         r = 1'b1;
         s = ID_W'($urandom_range(4095));
         d = ID_W'($urandom_range(4095));
      end else if (sel < 12) begin
         s = ID_W'($urandom_range(4095));
         d = ID_W'($urandom_range(4095));
      end else if (sel < 24) begin
         d = s;
      end
      send_route(s, d, r);
      plan_route(s, d, r);
   endtask

   // A route may end with no result, so the block gets its full latency before it counts as idle.
   task automatic drain_routes();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_entries.size() != 0) @(negedge clock);
      repeat (BUSY_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type r, input logic [31:0] v);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {r, 2'b00};
      csr_pwdata  = v;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic apply_torus(input cfg_type c);
      drain_routes();
      csr_write(CSR_DIM_COUNT, 32'(c.dim_count));
      csr_write(CSR_SIZE_X, 32'(c.size_x));
      csr_write(CSR_SIZE_Y, 32'(c.size_y));
      csr_write(CSR_SIZE_Z, 32'(c.size_z));
      csr_write(CSR_LOOPBACK_ON, 32'(c.loopback_on));
      csr_write(CSR_LIMITER_ON, 32'(c.limiter_on));
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      route_cfg   = c;
   endtask

   always @(negedge clock) rsp_stall = ($urandom_range(99) < rcv_stall_pct);

   always @(posedge clock) begin
      route_entry_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = kind_type'(rsp_entry_kind);
         got.node = rsp_link_node;
         got.dim  = rsp_link_dim;
         got.up   = rsp_use_up;
         got.last = rsp_last;
         if (expected_entries.size() == 0) begin
            fail_count++;
            if (fail_count <= 30)
               $display("%0t: unexpected entry kind=%0d node=%0d dim=%0d up=%0d last=%0d",
                        $time, got.kind, got.node, got.dim, got.up, got.last);
         end else begin
            want = expected_entries.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 30)
                  $display({"%0t: expected kind=%0d node=%0d dim=%0d up=%0d last=%0d,",
                            " got kind=%0d node=%0d dim=%0d up=%0d last=%0d"}, $time,
                           want.kind, want.node, want.dim, want.up, want.last,
                           got.kind, got.node, got.dim, got.up, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("torus_dimension_order_router_unit test failed");
      $finish;
   end

   initial begin
      int i, ph, seg, k, cur_set;
      cfg_type c;
      route_entry_type e;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_src_node      = '0;
      req_dst_node      = '0;
      req_end_is_router = 1'b0;
      rsp_stall         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      snd_idle_pct      = 20;
      rcv_stall_pct     = 56;
      route_cfg         = torus_sets[0];
      cur_set           = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < $size(directed_rows); i++) begin
         if (directed_rows[i].cfg_idx != cur_set) begin
            cur_set = directed_rows[i].cfg_idx;
            apply_torus(torus_sets[cur_set]);
         end
         send_route(directed_rows[i].src, directed_rows[i].dst, directed_rows[i].rtr);
         if (!directed_rows[i].typed) begin
            plan_route(directed_rows[i].src, directed_rows[i].dst, directed_rows[i].rtr);
         end else if (directed_rows[i].count == 1) begin
            e.kind = directed_rows[i].kind;
            e.node = directed_rows[i].node;
            e.dim  = 2'd0;
            e.up   = directed_rows[i].up;
            e.last = 1'b1;
            expected_entries.insert(expected_entries.size(), e);
         end
      end

      for (ph = 0; ph < 3; ph++) begin
         snd_idle_pct  = (ph == 0) ? 20 : (ph == 1) ? 56 : 0;
         rcv_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 20 : 0;
         for (seg = 0; seg < 4; seg++) begin
            c = random_torus();
            // One segment per phase runs the full 16x16x16 torus so every id bit is exercised.
            if (seg == ph) begin
               c.dim_count = 2'd3;
               c.size_x    = 5'd16;
               c.size_y    = 5'd16;
               c.size_z    = 5'd16;
            end
            apply_torus(c);
            for (k = 0; k < SEG_ITEMS; k++) send_random_route();
         end
      end

      drain_routes();
      if (fail_count == 0 && expected_entries.size() == 0) begin
         $display("torus_dimension_order_router_unit test passed");
      end else begin
         $display("torus_dimension_order_router_unit test failed");
      end
      $finish;
   end

endmodule
